// File: hdl/bsfr_pkg.sv
// Package for the byte-stuffed frame receiver: line codes, status and register codes,
// reset values and the CRC configuration bundle. No dependencies.
`default_nettype none

package bsfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STAT_W    = 2;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

  localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT_RST = 16'hFFFF;

  typedef enum logic [STAT_W-1:0] {
    STAT_GOOD     = 2'd0,
    STAT_BAD_LEN  = 2'd1,
    STAT_BAD_CRC  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } frame_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_POLY = 2'd0,
    CFG_CRC_INIT = 2'd1,
    CFG_CRC_REFL = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic             refl;
  } crc_cfg_t;

endpackage

`default_nettype wire

// File: hdl/bsfr_if.sv
// Valid/ready channel interfaces for the frame receiver: line input, result output
// and configuration writes. Depends on bsfr_pkg.
`default_nettype none

interface bsfr_in_if
  import bsfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_out_if
  import bsfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              data_valid;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_done;
  logic [STAT_W-1:0] frame_status;

  modport source (output valid, output data_valid, output data_byte, output frame_done,
                  output frame_status, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input frame_done,
                  input frame_status, output ready);
endinterface

interface bsfr_cfg_if
  import bsfr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CRC_W-1:0]     wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// File: hdl/bsfr_crc.sv
// Byte-wide CRC-16 update, normal or reflected bit order, with programmable polynomial.
// Depends on bsfr_pkg.
`default_nettype none

module bsfr_crc
  import bsfr_pkg::*;
(
  input  crc_cfg_t          cfg,
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [BYTE_W-1:0] data,
  output logic [CRC_W-1:0]  crc_out
);

  logic [CRC_W-1:0] rpoly;
  logic [CRC_W-1:0] c;

  always_comb begin
    for (int i = 0; i < CRC_W; i++) begin
      rpoly[i] = cfg.poly[CRC_W-1-i];
    end
    if (cfg.refl) begin
      c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
        c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
      end
    end else begin
      c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
        c = c[CRC_W-1] ? ((c << 1) ^ cfg.poly) : (c << 1);
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// File: hdl/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: unescapes line bytes, delays data two bytes, checks length/CRC.
// The result is registered and presented in the cycle after the byte is accepted.
// Accepts one line byte per cycle while in ready is high; the byte-wide CRC update feeds the CRC register.
// in ready stays high unless a result is held with out ready low.
// Reset (rst_n low, synchronous): registers to defaults, frame state cleared, output empty.
// Depends on bsfr_pkg, bsfr_if and bsfr_crc.
`default_nettype none

module byte_stuffed_frame_receiver
  import bsfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsfr_in_if.sink    in_ch,
  bsfr_out_if.source out_ch,
  bsfr_cfg_if.sink   cfg_ch
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

  // configuration
  crc_cfg_t         crc_cfg_r;
  logic [CRC_W-1:0] crc_init_r;

  // frame state
  logic              esc_r,  esc_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [BYTE_W-1:0] decl_r, decl_nxt;
  logic [BYTE_W-1:0] held0_r, held0_nxt;
  logic [BYTE_W-1:0] held1_r, held1_nxt;
  logic [CRC_W-1:0]  crc_r,  crc_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              dv_r, dv_nxt;
  logic [BYTE_W-1:0] db_r, db_nxt;
  logic              done_r, done_nxt;
  frame_status_t     stat_r, stat_nxt;

  logic              in_fire;
  logic [BYTE_W-1:0] b_data;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CRC_W-1:0]  crc_upd;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_valid   = dv_r;
  assign out_ch.data_byte    = db_r;
  assign out_ch.frame_done   = done_r;
  assign out_ch.frame_status = stat_r;

  bsfr_crc u_crc (
    .cfg     (crc_cfg_r),
    .crc_in  (crc_r),
    .data    (held0_r),
    .crc_out (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_cfg_r.poly <= CRC_POLY_RST;
      crc_cfg_r.refl <= 1'b0;
      crc_init_r     <= CRC_INIT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.reg_index)
        CFG_CRC_POLY: crc_cfg_r.poly <= cfg_ch.wr_data;
        CFG_CRC_INIT: crc_init_r     <= cfg_ch.wr_data;
        CFG_CRC_REFL: crc_cfg_r.refl <= cfg_ch.wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    decl_nxt  = decl_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    crc_nxt   = crc_r;
    dv_nxt    = 1'b0;
    db_nxt    = '0;
    done_nxt  = 1'b0;
    stat_nxt  = STAT_GOOD;
    b_data    = esc_r ? (in_ch.rx_byte ^ ESC_XOR) : in_ch.rx_byte;
    cnt_inc   = cnt_r + CNT_W'(1);

    if (!esc_r && in_ch.rx_byte == FLAG_BYTE) begin
      done_nxt = 1'b1;
      if (cnt_r < CNT_W'(4) || (16'(cnt_r) - 16'd4) != 16'(decl_r)) begin
        stat_nxt = STAT_BAD_LEN;
      end else if (crc_r != {held1_r, held0_r}) begin
        stat_nxt = STAT_BAD_CRC;
      end
      cnt_nxt   = '0;
      decl_nxt  = '0;
      held0_nxt = '0;
      held1_nxt = '0;
      crc_nxt   = crc_init_r;
    end else if (!esc_r && in_ch.rx_byte == ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      if (cnt_r >= CNT_W'(2)) begin
        dv_nxt  = 1'b1;
        db_nxt  = held0_r;
        crc_nxt = crc_upd;
      end
      if (cnt_r == CNT_W'(1)) begin
        decl_nxt = b_data;
      end
      held0_nxt = held1_r;
      held1_nxt = b_data;
      cnt_nxt   = cnt_inc;
      if (cnt_inc >= CNT_MAX) begin
        done_nxt  = 1'b1;
        stat_nxt  = STAT_OVERFLOW;
        cnt_nxt   = '0;
        decl_nxt  = '0;
        held0_nxt = '0;
        held1_nxt = '0;
        crc_nxt   = crc_init_r;
      end
    end

    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      decl_r      <= '0;
      held0_r     <= '0;
      held1_r     <= '0;
      crc_r       <= CRC_INIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        esc_r   <= esc_nxt;
        cnt_r   <= cnt_nxt;
        decl_r  <= decl_nxt;
        held0_r <= held0_nxt;
        held1_r <= held1_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dv_r   <= dv_nxt;
      db_r   <= db_nxt;
      done_r <= done_nxt;
      stat_r <= stat_nxt;
    end
  end

  // frame count never reaches the limit between beats
  a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_MAX)
    else $error("frame byte count at or above limit");

  // any frame end restarts the count
  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && done_nxt) |=> (cnt_r == '0))
    else $error("count not cleared after frame end");

  // a nonzero status only goes out with frame_done
  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !done_r) |-> (stat_r == STAT_GOOD))
    else $error("status without frame end");

  // an accepted beat always produces a result next cycle
  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat lost");

endmodule

`default_nettype wire
